// File: rtl/bpao_pkg.sv
// Shared constants and helpers for the byte pattern search block.
package bpao_pkg;

  localparam int unsigned MaxPatternDefault   = 16;
  localparam int unsigned PositionBitsDefault = 32;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned StoredBytes   = 16;
  localparam int unsigned PatternBits   = StoredBytes * ByteBits;
  localparam int unsigned PatIdxBits    = 6;
  localparam int unsigned CfgIndexBits  = 2;
  localparam int unsigned CfgDataBits   = 64;
  localparam int unsigned LengthRegBits = 5;
  localparam int unsigned MatchPosBits  = 32;

  localparam logic [CfgIndexBits-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CfgIndexBits-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CfgIndexBits-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // Pattern byte at index idx; bytes past the stored sixteen read as zero.
  function automatic logic [ByteBits-1:0] pat_byte(
    input logic [PatternBits-1:0] pat,
    input logic [PatIdxBits-1:0]  idx
  );
    logic [ByteBits-1:0] b;
    b = pat[8*idx[3:0] +: 8];
    if (idx >= PatIdxBits'(StoredBytes)) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

// File: rtl/byte_pattern_all_occurrences.sv
// Top level of the streaming byte pattern search.
//
// Usage: program the pattern over the cfg channel (index 0 = bytes 0..7,
// index 1 = bytes 8..15, index 2 = length 1..16) while the block is idle;
// cfg_ready_o is always high. Then stream the text one byte per request on
// the input channel, with text_start_i set on the first byte of each text.
// Every input request yields exactly one result request: match_found_o
// flags that an occurrence (overlaps included) ends at that byte and
// match_position_o gives its start index, zero otherwise.
// The request is held in the input register while the compare logic feeds
// the result register, which takes it once the result slot is free. Throughput
// is one byte per cycle while the receiver does not stall, set by the single
// compare pass over all pattern bytes. When the receiver stalls, the result
// register holds and the input register still takes one more request before
// in_ready_o drops.
// Reset empties both registers, clears the history and position, zeroes
// the pattern and sets the length to 1.
module byte_pattern_all_occurrences #(
  parameter int unsigned MAX_PATTERN   = bpao_pkg::MaxPatternDefault,
  parameter int unsigned POSITION_BITS = bpao_pkg::PositionBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpao_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [bpao_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          text_byte_i,
  input  logic                                text_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                match_found_o,
  output logic [bpao_pkg::MatchPosBits-1:0]   match_position_o
);

  localparam int unsigned LenBits  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WinSlots = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [bpao_pkg::PatternBits-1:0]  pattern;
  logic [LenBits-1:0]                len_m1;
  logic [WinSlots*8-1:0]             win;
  logic [LenBits-1:0]                fill;
  logic [POSITION_BITS-1:0]          pos;
  logic                              hit;
  logic [bpao_pkg::MatchPosBits-1:0] match_pos;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Result register.
  logic                              out_valid_q;
  logic                              out_found_q;
  logic [bpao_pkg::MatchPosBits-1:0] out_pos_q;

  logic out_free;
  logic advance;

  assign cfg_ready_o = 1'b1;

  // Result slot frees up when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the payload until the register is refilled.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= text_byte_i;
      in_start_q <= text_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_found_q <= hit;
      out_pos_q   <= match_pos;
    end
  end

  bpao_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_BITS    (LenBits)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern),
    .len_m1_o    (len_m1)
  );

  // History advances as the buffered byte moves into the result register.
  bpao_window #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS),
    .LEN_BITS      (LenBits),
    .WIN_SLOTS     (WinSlots)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .start_i   (in_start_q),
    .win_o     (win),
    .fill_o    (fill),
    .pos_o     (pos)
  );

  bpao_match #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS),
    .LEN_BITS      (LenBits),
    .WIN_SLOTS     (WinSlots)
  ) u_match (
    .pattern_i   (pattern),
    .len_m1_i    (len_m1),
    .byte_i      (in_byte_q),
    .win_i       (win),
    .fill_i      (fill),
    .pos_i       (pos),
    .hit_o       (hit),
    .match_pos_o (match_pos)
  );

  assign out_valid_o      = out_valid_q;
  assign match_found_o    = out_found_q;
  assign match_position_o = out_pos_q;

endmodule

// File: rtl/bpao_cfg.sv
// Configuration registers: pattern bytes and clamped pattern length.
module bpao_cfg #(
  parameter int unsigned MAX_PATTERN = bpao_pkg::MaxPatternDefault,
  parameter int unsigned LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpao_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [bpao_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic [bpao_pkg::PatternBits-1:0]    pattern_o,
  output logic [LEN_BITS-1:0]                 len_m1_o
);

  logic [bpao_pkg::CfgDataBits-1:0]   pat_low_q;
  logic [bpao_pkg::CfgDataBits-1:0]   pat_high_q;
  logic [bpao_pkg::LengthRegBits-1:0] len_q;
  logic [6:0]                         len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= bpao_pkg::LengthRegBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bpao_pkg::CFG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        bpao_pkg::CFG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        bpao_pkg::CFG_PATTERN_LENGTH: len_q      <= cfg_data_i[bpao_pkg::LengthRegBits-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length into 1..MAX_PATTERN.
  always_comb begin
    len_eff = {2'b00, len_q};
    if (len_q == '0) begin
      len_eff = 7'd1;
    end else if (len_eff > 7'(MAX_PATTERN)) begin
      len_eff = 7'(MAX_PATTERN);
    end
  end

  assign len_m1_o  = LEN_BITS'(len_eff - 7'd1);
  assign pattern_o = {pat_high_q, pat_low_q};

endmodule

// File: rtl/bpao_window.sv
// Text history: recent bytes, fill count and byte position of the current text.
module bpao_window #(
  parameter int unsigned MAX_PATTERN   = bpao_pkg::MaxPatternDefault,
  parameter int unsigned POSITION_BITS = bpao_pkg::PositionBitsDefault,
  parameter int unsigned LEN_BITS      = $clog2(MAX_PATTERN + 1),
  parameter int unsigned WIN_SLOTS     = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [7:0]                  byte_i,
  input  logic                        start_i,
  output logic [WIN_SLOTS*8-1:0]      win_o,
  output logic [LEN_BITS-1:0]         fill_o,
  output logic [POSITION_BITS-1:0]    pos_o
);

  localparam int unsigned WinDepth = MAX_PATTERN - 1;
  localparam int unsigned WinW     = WIN_SLOTS * 8;

  logic [WinW-1:0]          win_q, win_d;
  logic [LEN_BITS-1:0]      fill_q, fill_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  // A new text sees an empty history.
  assign win_o  = start_i ? '0 : win_q;
  assign fill_o = start_i ? '0 : fill_q;
  assign pos_o  = start_i ? '0 : pos_q;

  always_comb begin
    win_d  = WinW'({win_o, byte_i});
    fill_d = fill_o;
    if (fill_o < LEN_BITS'(WinDepth)) begin
      fill_d = fill_o + LEN_BITS'(1);
    end
    pos_d = pos_o;
    if (pos_o != '1) begin
      pos_d = pos_o + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
    end else if (advance_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: rtl/bpao_match.sv
// Parallel compare of the pattern against the newest byte and the history.
module bpao_match #(
  parameter int unsigned MAX_PATTERN   = bpao_pkg::MaxPatternDefault,
  parameter int unsigned POSITION_BITS = bpao_pkg::PositionBitsDefault,
  parameter int unsigned LEN_BITS      = $clog2(MAX_PATTERN + 1),
  parameter int unsigned WIN_SLOTS     = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
  input  logic [bpao_pkg::PatternBits-1:0]  pattern_i,
  input  logic [LEN_BITS-1:0]               len_m1_i,
  input  logic [7:0]                        byte_i,
  input  logic [WIN_SLOTS*8-1:0]            win_i,
  input  logic [LEN_BITS-1:0]               fill_i,
  input  logic [POSITION_BITS-1:0]          pos_i,
  output logic                              hit_o,
  output logic [bpao_pkg::MatchPosBits-1:0] match_pos_o
);

  logic [WIN_SLOTS-1:0]     slot_ok;
  logic                     last_ok;
  logic [POSITION_BITS-1:0] start_pos;

  // History slot k holds the byte k+1 back; it must equal pattern byte len-2-k.
  for (genvar k = 0; k < WIN_SLOTS; k++) begin : g_slot
    logic       active;
    logic [7:0] idx;
    assign active = (8'(len_m1_i) > 8'(k));
    assign idx    = 8'(len_m1_i) - 8'(k + 1);
    assign slot_ok[k] = !active ||
      (bpao_pkg::pat_byte(pattern_i, idx[bpao_pkg::PatIdxBits-1:0]) == win_i[8*k +: 8]);
  end

  assign last_ok = (bpao_pkg::pat_byte(pattern_i,
                     bpao_pkg::PatIdxBits'(len_m1_i)) == byte_i);
  assign hit_o   = (fill_i >= len_m1_i) && last_ok && (&slot_ok);

  assign start_pos = pos_i - POSITION_BITS'(len_m1_i);

  if (POSITION_BITS >= bpao_pkg::MatchPosBits) begin : g_trunc
    assign match_pos_o = hit_o ? start_pos[bpao_pkg::MatchPosBits-1:0] : '0;
  end else begin : g_ext
    assign match_pos_o = hit_o ? bpao_pkg::MatchPosBits'(start_pos) : '0;
  end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the streaming byte pattern search block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpao_pkg::*;

  localparam int unsigned HistDepth = MaxPatternDefault - 1;

  // One result request as the block should return it.
  typedef struct packed {
    logic                    found;
    logic [MatchPosBits-1:0] start;
  } match_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexBits-1:0]  cfg_index_i  = CFG_PATTERN_LOW;
  logic [CfgDataBits-1:0]   cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               text_byte_i  = '0;
  logic                     text_start_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic                     match_found_o;
  logic [MatchPosBits-1:0]  match_position_o;

  // Shadow of the block: pattern registers, byte history and text index.
  logic [PatternBits-1:0]   pattern_bytes = '0;
  logic [LengthRegBits-1:0] length_reg    = LengthRegBits'(1);
  logic [7:0]               seen_bytes [HistDepth];
  int unsigned              seen_count    = 0;
  logic [MatchPosBits-1:0]  next_index    = '0;

  match_t      expected_matches [$];
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          fresh_text    = 1'b1;

  byte_pattern_all_occurrences DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .text_start_i     (text_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_found_o    (match_found_o),
    .match_position_o (match_position_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case a request or a result never shows up.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Stall the result channel at random; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Length in use: zero counts as one, anything past the maximum is clamped.
  function automatic int unsigned active_length();
    if (length_reg == 0) return 1;
    if (length_reg > MaxPatternDefault) return MaxPatternDefault;
    return length_reg;
  endfunction

  // Work out the result for one accepted byte and advance the shadow state.
  function automatic void scan_byte(input logic [7:0] b, input logic s);
    match_t      m;
    int unsigned span;
    bit          hit;
    if (s) begin
      // A new text clears the history and restarts the index at zero.
      for (int k = 0; k < HistDepth; k++) seen_bytes[k] = '0;
      seen_count = 0;
      next_index = '0;
    end
    span = active_length();
    // The last pattern byte meets the incoming byte; the earlier ones meet
    // the history, most recent byte first.
    hit = (seen_count >= span - 1) && (pattern_bytes[8*(span-1) +: 8] == b);
    for (int k = 0; k + 1 < span; k++) begin
      if (pattern_bytes[8*(span-2-k) +: 8] != seen_bytes[k]) hit = 1'b0;
    end
    m.found = hit;
    m.start = hit ? next_index - MatchPosBits'(span - 1) : '0;
    expected_matches.push_back(m);
    for (int k = HistDepth - 1; k > 0; k--) seen_bytes[k] = seen_bytes[k-1];
    seen_bytes[0] = b;
    if (seen_count < HistDepth) seen_count++;
    // Hold the index once it saturates.
    if (next_index != '1) next_index++;
  endfunction

  // Check every result request against the oldest prediction. Inputs only
  // change at the rising edge, so a handshake seen here completes at the
  // next rising edge.
  always @(negedge clk_i) begin : check_results
    match_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_matches.size() == 0) begin
        $display("%0t ns: unexpected result found=%0b position=%0d", $time,
                 match_found_o, match_position_o);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (match_found_o !== want.found) begin
          $display("%0t ns: match_found expected %0b actual %0b", $time,
                   want.found, match_found_o);
          errors++;
        end
        if (match_position_o !== want.start) begin
          $display("%0t ns: match_position expected %0d actual %0d", $time,
                   want.start, match_position_o);
          errors++;
        end
      end
    end
  end

  // Send one text byte: optional idle gap, then hold the request until taken.
  task automatic push_byte(input logic [7:0] b, input logic s);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    text_start_i <= s;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    scan_byte(b, s);
    items_sent++;
  endtask

  // Write one register; keep the request raised when more writes follow.
  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data, input bit last);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      CFG_PATTERN_LOW:    pattern_bytes[63:0]   = data;
      CFG_PATTERN_HIGH:   pattern_bytes[127:64] = data;
      CFG_PATTERN_LENGTH: length_reg            = data[LengthRegBits-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic load_pattern(input logic [PatternBits-1:0] pat,
                              input logic [CfgDataBits-1:0] len_word);
    write_reg(CFG_PATTERN_LOW, pat[63:0], 1'b0);
    write_reg(CFG_PATTERN_HIGH, pat[127:64], 1'b0);
    write_reg(CFG_PATTERN_LENGTH, len_word, 1'b1);
  endtask

  // Drop the input request and wait for every outstanding result, then let
  // the pipeline empty before anything touches the registers.
  task automatic drain_results();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_matches.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_matches.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_matches.size());
      errors++;
      expected_matches.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Start flag for the next random byte: forced on the first byte of a
  // segment that asks for a fresh text, rare otherwise.
  function automatic logic pick_start();
    logic s;
    s = fresh_text || ($urandom_range(99) < 4);
    fresh_text = 1'b0;
    return s;
  endfunction

  // Reset values: all-zero pattern of length one, so a zero byte matches.
  task automatic test_reset_defaults();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    drain_results();
  endtask

  // Longest pattern with extreme byte values, planted right at text start.
  task automatic test_full_length();
    logic [PatternBits-1:0] pat;
    pat = 128'h7F_C3_3C_FE_02_E7_18_81_7E_80_01_A5_5A_00_FF_00;
    pat[7:0] = 8'hFF;
    load_pattern(pat, CfgDataBits'(16));
    for (int i = 0; i < 16; i++) push_byte(pat[8*i +: 8], i == 0);
    drain_results();
  endtask

  // Overlapping hits, then a new text that must forget the old window.
  task automatic test_overlap_restart();
    load_pattern(PatternBits'(16'h6161), CfgDataBits'(2));
    push_byte(8'h61, 1'b1);
    push_byte(8'h61, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h61, 1'b0);
    drain_results();
  endtask

  // A length of zero behaves as a single-byte pattern.
  task automatic test_zero_length();
    load_pattern(PatternBits'(8'h7E), CfgDataBits'(0));
    push_byte(8'h7E, 1'b1);
    drain_results();
  endtask

  // Random patterns and texts: mostly planted occurrences and bytes drawn
  // from the pattern, with some noise and broken runs from stray starts.
  task automatic test_random_texts();
    logic [PatternBits-1:0] pat;
    logic [CfgDataBits-1:0] len_word;
    logic [7:0]             sym_a, sym_b;
    logic [4:0]             len;
    int unsigned            base, span, pick;
    while (items_sent < 480) begin
      // Idle phases: sender-light, then receiver-light, then none at all.
      if (items_sent < 200) begin
        send_idle_pct = 28;
        recv_idle_pct = 46;
      end else if (items_sent < 370) begin
        send_idle_pct = 46;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pat = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(1)) begin
        // Two-symbol alphabet makes repeats and overlaps common.
        sym_a = 8'($urandom);
        sym_b = 8'($urandom);
        for (int i = 0; i < 16; i++) pat[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
      end
      case ($urandom_range(9))
        0:       len = 5'd0;
        1:       len = 5'($urandom_range(17, 31));
        2:       len = 5'd16;
        3:       len = 5'd1;
        default: len = 5'($urandom_range(1, 16));
      endcase
      len_word = CfgDataBits'(len);
      // Upper data bits of the length write are ignored; exercise them too.
      if ($urandom_range(3) == 0) len_word = {$urandom, 27'($urandom), len};
      load_pattern(pat, len_word);
      span = active_length();
      fresh_text = $urandom_range(3) != 0;
      base = items_sent;
      while (items_sent - base < 40) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          for (int j = 0; j < span; j++) push_byte(pat[8*j +: 8], pick_start());
        end else if (pick < 85) begin
          push_byte(pat[8*$urandom_range(span - 1) +: 8], pick_start());
        end else begin
          push_byte(8'($urandom), pick_start());
        end
      end
      drain_results();
    end
  endtask

  initial begin
    for (int k = 0; k < HistDepth; k++) seen_bytes[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 28;
    recv_idle_pct = 46;
    test_reset_defaults();
    test_full_length();
    test_overlap_restart();
    test_zero_length();
    test_random_texts();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
